[src/uwv_pkg.sv]
package uwv_pkg;

  localparam int TIME_W  = 24;
  localparam int PATH_W  = 20;
  localparam int COMP_W  = 18;
  localparam int DIR_W   = 15;
  localparam int STAT_W  = 2;
  localparam int PD_W    = 44;
  localparam int PP_W    = 48;
  localparam int HALF_W  = 22;
  localparam int PART_W  = 42;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 49;
  localparam int REM_W   = 67;
  localparam int Q_W     = 18;
  localparam int SQ_W    = 36;
  localparam int CX_W    = 32;
  localparam int ANG_W   = 24;
  localparam int TAB_LEN = 24;

  localparam logic [PATH_W-1:0] PATH_RESET = 20'd200000;
  localparam logic [19:0] SCALE_MICRO = 20'd1000000;
  localparam logic signed [COMP_W-1:0] COMP_MAX = 18'sd131071;
  localparam logic signed [COMP_W-1:0] COMP_MIN = -18'sd131072;
  localparam logic signed [DIR_W-1:0] DIR_MAX = 15'sd9000;
  localparam logic signed [DIR_W-1:0] DIR_MIN = -15'sd9000;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

  localparam logic REG_X_PATH = 1'b0;
  localparam logic REG_Y_PATH = 1'b1;

  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } div_sb_t;

  typedef struct packed {
    logic                     zero;
    logic                     sat;
    logic signed [COMP_W-1:0] vx;
    logic signed [COMP_W-1:0] vy;
    logic signed [CX_W-1:0]   x0;
    logic signed [CX_W-1:0]   y0;
    logic [COMP_W-1:0]        mag;
  } post_sb_t;

  // atan(2^-i) in 1/256 hundredths of a degree.
  function automatic logic signed [ANG_W-1:0] atan_tab(input int unsigned i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      0: a = 24'sd1152000;
      1: a = 24'sd680065;
      2: a = 24'sd359328;
      3: a = 24'sd182400;
      4: a = 24'sd91554;
      5: a = 24'sd45822;
      6: a = 24'sd22916;
      7: a = 24'sd11459;
      8: a = 24'sd5730;
      9: a = 24'sd2865;
      10: a = 24'sd1432;
      11: a = 24'sd716;
      12: a = 24'sd358;
      13: a = 24'sd179;
      14: a = 24'sd90;
      15: a = 24'sd45;
      16: a = 24'sd22;
      17: a = 24'sd11;
      18: a = 24'sd6;
      19: a = 24'sd3;
      20: a = 24'sd1;
      21: a = 24'sd1;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

[src/uwv_div_cell.sv]
module uwv_div_cell
  import uwv_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [REM_W-1:0] in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  logic [Q_W-1:0]   in_q,
  output logic             out_valid,
  output logic [REM_W-1:0] out_rem,
  output logic [DEN_W-1:0] out_den,
  output logic [Q_W-1:0]   out_q
);

  logic [REM_W-1:0] trial;
  logic             ge;

  assign trial = {{(REM_W-DEN_W){1'b0}}, in_den} << BIT;
  assign ge    = in_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den <= in_den;
    out_rem <= ge ? in_rem - trial : in_rem;
    out_q   <= in_q | (ge ? {{(Q_W-1){1'b0}}, 1'b1} << BIT : {Q_W{1'b0}});
  end

endmodule

[src/uwv_sqrt_cell.sv]
module uwv_sqrt_cell
  import uwv_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_rem,
  input  logic [COMP_W-1:0] in_root,
  output logic              out_valid,
  output logic [SQ_W-1:0]   out_rem,
  output logic [COMP_W-1:0] out_root
);

  logic [SQ_W+1:0] trial;
  logic            ge;

  assign trial = ({{(SQ_W+2-COMP_W){1'b0}}, in_root} << (BIT + 1))
               + ({{(SQ_W+1){1'b0}}, 1'b1} << (2 * BIT));
  assign ge    = {2'b00, in_rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem  <= ge ? in_rem - trial[SQ_W-1:0] : in_rem;
    out_root <= in_root | (ge ? {{(COMP_W-1){1'b0}}, 1'b1} << BIT : {COMP_W{1'b0}});
  end

endmodule

[src/uwv_cordic_cell.sv]
module uwv_cordic_cell
  import uwv_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [CX_W-1:0]  in_x,
  input  logic signed [CX_W-1:0]  in_y,
  input  logic signed [ANG_W-1:0] in_z,
  output logic                    out_valid,
  output logic signed [CX_W-1:0]  out_x,
  output logic signed [CX_W-1:0]  out_y,
  output logic signed [ANG_W-1:0] out_z
);

  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  logic signed [ANG_W-1:0] ang;

  assign dx  = in_y >>> STEP;
  assign dy  = in_x >>> STEP;
  assign ang = atan_tab(STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    if (!in_y[CX_W-1]) begin
      out_x <= in_x + dx;
      out_y <= in_y - dy;
      out_z <= in_z + ang;
    end else begin
      out_x <= in_x - dx;
      out_y <= in_y + dy;
      out_z <= in_z - ang;
    end
  end

endmodule

[src/ultrasonic_wind_vector_unit.sv]
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The divider and square root each use one cell per result bit, the CORDIC one cell per step.
// Reset (synchronous) clears all valid bits and sets both path registers to 200000 um.
// The receiver cannot stall; each result is shown for one cycle with done high.
module ultrasonic_wind_vector_unit
  import uwv_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [TIME_W-1:0]        x_pos_ns,
  input  logic [TIME_W-1:0]        x_neg_ns,
  input  logic [TIME_W-1:0]        y_pos_ns,
  input  logic [TIME_W-1:0]        y_neg_ns,
  input  logic                     wr_en,
  input  logic                     wr_index,
  input  logic [PATH_W-1:0]        wr_data,
  output logic                     done,
  output logic signed [COMP_W-1:0] x_speed_mm_s,
  output logic signed [COMP_W-1:0] y_speed_mm_s,
  output logic [COMP_W-1:0]        speed_mm_s,
  output logic signed [DIR_W-1:0]  direction_cdeg,
  output logic [STAT_W-1:0]        status
);

  localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  logic [PATH_W-1:0] x_path_um;
  logic [PATH_W-1:0] y_path_um;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_path_um <= PATH_RESET;
      y_path_um <= PATH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_X_PATH: x_path_um <= wr_data;
        REG_Y_PATH: y_path_um <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic              a_v;
  logic [TIME_W-1:0] a_tp [2];
  logic [TIME_W-1:0] a_tn [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
    a_tp[0] <= x_pos_ns;
    a_tn[0] <= x_neg_ns;
    a_tp[1] <= y_pos_ns;
    a_tn[1] <= y_neg_ns;
  end

  // Path times difference and transit time product.
  logic              b_v;
  logic [PD_W-1:0]   b_pd [2];
  logic [PP_W-1:0]   b_pp [2];
  div_sb_t           b_sb;
  logic [TIME_W-1:0] a_diff [2];
  logic              a_neg [2];
  logic [PATH_W-1:0] a_path [2];

  always_comb begin
    a_path[0] = x_path_um;
    a_path[1] = y_path_um;
    for (int k = 0; k < 2; k++) begin
      a_neg[k]  = a_tp[k] > a_tn[k];
      a_diff[k] = a_neg[k] ? a_tp[k] - a_tn[k] : a_tn[k] - a_tp[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
    for (int k = 0; k < 2; k++) begin
      b_pd[k] <= PD_W'(a_path[k] * a_diff[k]);
      b_pp[k] <= PP_W'(a_tp[k] * a_tn[k]);
    end
    b_sb.zero  <= (a_tp[0] == '0) || (a_tn[0] == '0) || (a_tp[1] == '0) || (a_tn[1] == '0);
    b_sb.neg_x <= a_neg[0];
    b_sb.neg_y <= a_neg[1];
    b_sb.ovf_x <= 1'b0;
    b_sb.ovf_y <= 1'b0;
  end

  // Numerator partial products.
  logic              c_v;
  logic [PART_W-1:0] c_lo [2];
  logic [PART_W-1:0] c_hi [2];
  logic [PP_W-1:0]   c_pp [2];
  div_sb_t           c_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b_v;
    end
    for (int k = 0; k < 2; k++) begin
      c_lo[k] <= PART_W'(b_pd[k][HALF_W-1:0] * SCALE_MICRO);
      c_hi[k] <= PART_W'(b_pd[k][PD_W-1:HALF_W] * SCALE_MICRO);
      c_pp[k] <= b_pp[k];
    end
    c_sb <= b_sb;
  end

  // Rounded dividend, divisor and overflow check; then one cell per quotient bit.
  logic             dv   [2][Q_W+1];
  logic [REM_W-1:0] drem [2][Q_W+1];
  logic [DEN_W-1:0] dden [2][Q_W+1];
  logic [Q_W-1:0]   dq   [2][Q_W+1];
  div_sb_t          dsb  [Q_W+1];
  logic [NUM_W-1:0] c_num [2];
  logic [REM_W-1:0] c_nr  [2];
  logic [DEN_W-1:0] c_den [2];
  logic             c_ovf [2];
  div_sb_t          c_sb_ovf;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      c_num[k] = ({{(NUM_W-PART_W){1'b0}}, c_hi[k]} << HALF_W)
               + {{(NUM_W-PART_W){1'b0}}, c_lo[k]};
      c_nr[k]  = {{(REM_W-NUM_W){1'b0}}, c_num[k]} + {{(REM_W-PP_W){1'b0}}, c_pp[k]};
      c_den[k] = {c_pp[k], 1'b0};
      c_ovf[k] = c_nr[k] >= {c_den[k], {Q_W{1'b0}}};
    end
    c_sb_ovf       = c_sb;
    c_sb_ovf.ovf_x = c_ovf[0];
    c_sb_ovf.ovf_y = c_ovf[1];
  end

  always_ff @(posedge clk) begin
    dsb[0] <= c_sb_ovf;
    for (int j = 1; j <= Q_W; j++) begin
      dsb[j] <= dsb[j-1];
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[ax][0] <= 1'b0;
      end else begin
        dv[ax][0] <= c_v;
      end
      drem[ax][0] <= c_nr[ax];
      dden[ax][0] <= c_den[ax];
      dq[ax][0]   <= '0;
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
      uwv_div_cell #(.BIT(Q_W - 1 - j)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (dv[ax][j]),
        .in_rem    (drem[ax][j]),
        .in_den    (dden[ax][j]),
        .in_q      (dq[ax][j]),
        .out_valid (dv[ax][j+1]),
        .out_rem   (drem[ax][j+1]),
        .out_den   (dden[ax][j+1]),
        .out_q     (dq[ax][j+1])
      );
    end
  end

  // Rounding done by the biased dividend; saturate each component.
  logic                     e_v;
  post_sb_t                 e_sb;
  logic signed [COMP_W-1:0] d_vx;
  logic signed [COMP_W-1:0] d_vy;
  logic                     d_sx;
  logic                     d_sy;
  logic [Q_W-1:0]           qx;
  logic [Q_W-1:0]           qy;

  assign qx = dq[0][Q_W];
  assign qy = dq[1][Q_W];

  always_comb begin
    if (!dsb[Q_W].neg_x) begin
      d_sx = dsb[Q_W].ovf_x || qx[Q_W-1];
      d_vx = d_sx ? COMP_MAX : $signed(qx);
    end else begin
      d_sx = dsb[Q_W].ovf_x || (qx > Q_W'(131072));
      d_vx = d_sx ? COMP_MIN : $signed(-qx);
    end
    if (!dsb[Q_W].neg_y) begin
      d_sy = dsb[Q_W].ovf_y || qy[Q_W-1];
      d_vy = d_sy ? COMP_MAX : $signed(qy);
    end else begin
      d_sy = dsb[Q_W].ovf_y || (qy > Q_W'(131072));
      d_vy = d_sy ? COMP_MIN : $signed(-qy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else begin
      e_v <= dv[0][Q_W] && dv[1][Q_W];
    end
    e_sb.zero <= dsb[Q_W].zero;
    e_sb.sat  <= d_sx || d_sy;
    e_sb.vx   <= d_vx;
    e_sb.vy   <= d_vy;
    e_sb.x0   <= '0;
    e_sb.y0   <= '0;
    e_sb.mag  <= '0;
  end

  // Squares and CORDIC start vector.
  logic                   f_v;
  logic [SQ_W-1:0]        f_sqx;
  logic [SQ_W-1:0]        f_sqy;
  post_sb_t               f_sb;
  logic signed [CX_W-1:0] e_vx32;
  logic signed [CX_W-1:0] e_vy32;
  post_sb_t               e_sb_rot;

  assign e_vx32 = CX_W'(e_sb.vx);
  assign e_vy32 = CX_W'(e_sb.vy);

  always_comb begin
    e_sb_rot    = e_sb;
    e_sb_rot.x0 = (e_sb.vy < 0) ? (-e_vy32) <<< 8 : e_vy32 <<< 8;
    e_sb_rot.y0 = (e_sb.vy < 0) ? (-e_vx32) <<< 8 : e_vx32 <<< 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else begin
      f_v <= e_v;
    end
    f_sqx <= SQ_W'(e_sb.vx * e_sb.vx);
    f_sqy <= SQ_W'(e_sb.vy * e_sb.vy);
    f_sb  <= e_sb_rot;
  end

  // Square root, one cell per root bit.
  logic              sv    [COMP_W+1];
  logic [SQ_W-1:0]   srem  [COMP_W+1];
  logic [COMP_W-1:0] sroot [COMP_W+1];
  post_sb_t          psb   [COMP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= f_v;
    end
    srem[0]  <= f_sqx + f_sqy;
    sroot[0] <= '0;
    psb[0]   <= f_sb;
    for (int j = 1; j <= COMP_W; j++) begin
      psb[j] <= psb[j-1];
    end
  end

  for (genvar j = 0; j < COMP_W; j++) begin : g_sqrt
    uwv_sqrt_cell #(.BIT(COMP_W - 1 - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[j]),
      .in_rem    (srem[j]),
      .in_root   (sroot[j]),
      .out_valid (sv[j+1]),
      .out_rem   (srem[j+1]),
      .out_root  (sroot[j+1])
    );
  end

  // Round the root, then one CORDIC cell per step.
  logic                    cv  [NSTEP+1];
  logic signed [CX_W-1:0]  cx  [NSTEP+1];
  logic signed [CX_W-1:0]  cy  [NSTEP+1];
  logic signed [ANG_W-1:0] cz  [NSTEP+1];
  post_sb_t                qsb [NSTEP+1];
  post_sb_t                s_sb;

  always_comb begin
    s_sb     = psb[COMP_W];
    s_sb.mag = sroot[COMP_W]
             + {{(COMP_W-1){1'b0}},
                (srem[COMP_W] > {{(SQ_W-COMP_W){1'b0}}, sroot[COMP_W]})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= sv[COMP_W];
    end
    cx[0]  <= psb[COMP_W].x0;
    cy[0]  <= psb[COMP_W].y0;
    cz[0]  <= '0;
    qsb[0] <= s_sb;
    for (int j = 1; j <= NSTEP; j++) begin
      qsb[j] <= qsb[j-1];
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_cordic
    uwv_cordic_cell #(.STEP(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[j]),
      .in_x      (cx[j]),
      .in_y      (cy[j]),
      .in_z      (cz[j]),
      .out_valid (cv[j+1]),
      .out_x     (cx[j+1]),
      .out_y     (cy[j+1]),
      .out_z     (cz[j+1])
    );
  end

  // Final angle rounding, special directions and the output register.
  post_sb_t                 fin;
  logic signed [ANG_W-1:0]  z_rnd;
  logic signed [DIR_W:0]    z_res;
  logic signed [DIR_W-1:0]  dir;

  assign fin   = qsb[NSTEP];
  assign z_rnd = (cz[NSTEP] + ANG_W'(128)) >>> 8;
  assign z_res = (DIR_W+1)'(z_rnd);

  always_comb begin
    if (fin.vy == 0) begin
      dir = (fin.vx > 0) ? DIR_MAX : ((fin.vx < 0) ? DIR_MIN : '0);
    end else if (fin.vx == 0) begin
      dir = '0;
    end else if (z_res > 16'sd9000) begin
      dir = DIR_MAX;
    end else if (z_res < -16'sd9000) begin
      dir = DIR_MIN;
    end else begin
      dir = z_res[DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[NSTEP];
    end
    if (fin.zero) begin
      x_speed_mm_s   <= '0;
      y_speed_mm_s   <= '0;
      speed_mm_s     <= '0;
      direction_cdeg <= '0;
      status         <= STAT_ZERO;
    end else begin
      x_speed_mm_s   <= fin.vx;
      y_speed_mm_s   <= fin.vy;
      speed_mm_s     <= fin.mag;
      direction_cdeg <= dir;
      status         <= fin.sat ? STAT_SAT : STAT_OK;
    end
  end

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (direction_cdeg <= DIR_MAX) && (direction_cdeg >= DIR_MIN))
    else $error("direction out of range");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_ZERO) |->
      (x_speed_mm_s == 0) && (y_speed_mm_s == 0) && (speed_mm_s == 0)
      && (direction_cdeg == 0))
    else $error("zero time beat carries nonzero fields");

  a_dir_on_axis: assert property (@(posedge clk) disable iff (rst)
    (done && y_speed_mm_s == 0) |->
      (direction_cdeg == DIR_MAX) || (direction_cdeg == DIR_MIN) || (direction_cdeg == 0))
    else $error("direction wrong for zero y component");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_ZERO) |-> (speed_mm_s <= 18'd185364))
    else $error("magnitude above the largest possible vector");

endmodule

[tb/ultrasonic_wind_vector_unit_test.sv]
module ultrasonic_wind_vector_unit_test;
  import uwv_pkg::*;

  localparam int STEPS = 16;
  localparam int DRAIN = 90;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [COMP_W-1:0] vx;
    logic signed [COMP_W-1:0] vy;
    logic [COMP_W-1:0]        mag;
    logic signed [DIR_W-1:0]  dir;
    logic [STAT_W-1:0]        st;
  } wind_t;

  typedef struct {
    logic [TIME_W-1:0] xp, xn, yp, yn;
    bit                known;
    wind_t             w;
  } row_t;

  localparam longint ATAN_LUT [24] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

  logic clk = 0, rst = 1, start = 0, wr_en = 0, wr_index = REG_X_PATH;
  logic [TIME_W-1:0] x_pos_ns = '0, x_neg_ns = '0, y_pos_ns = '0, y_neg_ns = '0;
  logic [PATH_W-1:0] wr_data = '0;
  logic busy, done;
  logic signed [COMP_W-1:0] x_speed_mm_s, y_speed_mm_s;
  logic [COMP_W-1:0] speed_mm_s;
  logic signed [DIR_W-1:0] direction_cdeg;
  logic [STAT_W-1:0] status;

  longint unsigned path_x = PATH_RESET, path_y = PATH_RESET;
  wind_t pending_winds[$];
  int errors = 0, results_seen = 0, items_sent = 0, cycles = 0;

  ultrasonic_wind_vector_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [COMP_W-1:0] axis_speed(input longint unsigned path,
      input longint unsigned tp, input longint unsigned tn, inout bit sat);
    longint unsigned diff, num, den, q;
    bit neg;
    neg = tp > tn;
    diff = neg ? tp - tn : tn - tp;
    num = path * diff * 64'd1000000;
    den = 2 * tp * tn;
    q = (num + den / 2) / den;
    if (!neg) begin
      if (q > 131071) begin
        sat = 1;
        return COMP_MAX;
      end
      return COMP_W'(q);
    end
    if (q > 131072) begin
      sat = 1;
      return COMP_MIN;
    end
    return COMP_W'(-longint'(q));
  endfunction

  function automatic longint unsigned rounded_root(input longint unsigned v);
    longint unsigned r, b, rem;
    r = 0;
    b = 64'd1 << 62;
    rem = v;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (rem > r) r += 1;
    return r;
  endfunction

  function automatic longint heading(input longint vx, input longint vy);
    longint x, y, z, dx, dy, res;
    z = 0;
    if (vy == 0) return vx > 0 ? 9000 : (vx < 0 ? -9000 : 0);
    if (vx == 0) return 0;
    x = (vy < 0 ? -vy : vy) * 256;
    y = (vy < 0 ? -vx : vx) * 256;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_LUT[i];
      end
    end
    res = (z + 128) >>> 8;
    if (res > 9000) res = 9000;
    if (res < -9000) res = -9000;
    return res;
  endfunction

  function automatic wind_t wind_vector(input logic [TIME_W-1:0] xp, xn, yp, yn);
    wind_t w;
    bit sat;
    longint vx, vy;
    sat = 0;
    if (xp == 0 || xn == 0 || yp == 0 || yn == 0) begin
      w = '{0, 0, 0, 0, STAT_ZERO};
      return w;
    end
    w.vx = axis_speed(path_x, xp, xn, sat);
    w.vy = axis_speed(path_y, yp, yn, sat);
    vx = w.vx;
    vy = w.vy;
    w.mag = COMP_W'(rounded_root(longint'(vx * vx + vy * vy)));
    w.dir = DIR_W'(heading(vx, vy));
    w.st = sat ? STAT_SAT : STAT_OK;
    return w;
  endfunction

  always @(posedge clk) begin
    wind_t e;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_winds.size() == 0) begin
        $error("result beat with no expected result waiting");
        errors++;
      end else begin
        e = pending_winds.pop_front();
        if (x_speed_mm_s !== e.vx) begin
          $error("x_speed_mm_s: expected %0d, got %0d", e.vx, x_speed_mm_s);
          errors++;
        end
        if (y_speed_mm_s !== e.vy) begin
          $error("y_speed_mm_s: expected %0d, got %0d", e.vy, y_speed_mm_s);
          errors++;
        end
        if (speed_mm_s !== e.mag) begin
          $error("speed_mm_s: expected %0d, got %0d", e.mag, speed_mm_s);
          errors++;
        end
        if (direction_cdeg !== e.dir) begin
          $error("direction_cdeg: expected %0d, got %0d", e.dir, direction_cdeg);
          errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  task automatic write_path(input logic idx, input logic [PATH_W-1:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    if (idx == REG_X_PATH) path_x = val;
    else path_y = val;
  endtask

  // Start is left high across back-to-back beats when the next gap is zero.
  task automatic send(input logic [TIME_W-1:0] xp, xn, yp, yn, input bit known,
      input wind_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    x_pos_ns <= xp;
    x_neg_ns <= xn;
    y_pos_ns <= yp;
    y_neg_ns <= yn;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_winds.push_back(known ? w : wind_vector(xp, xn, yp, yn));
    items_sent++;
  endtask

  task automatic settle();
    start <= 0;
    while (pending_winds.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] random_time();
    return TIME_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 255) : $urandom);
  endfunction

  task automatic random_items(input int count);
    logic [TIME_W-1:0] t[4];
    int base, d;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          for (int a = 0; a < 2; a++) begin
            base = $urandom_range(1000, 2000000);
            d = $urandom_range(0, base / 20);
            t[2*a] = TIME_W'(base);
            t[2*a+1] = TIME_W'($urandom_range(0, 1) ? base + d : base - d);
          end
        end
        6, 7, 8: foreach (t[k]) t[k] = random_time();
        default: begin
          foreach (t[k]) t[k] = TIME_W'($urandom_range(1, 24'hFFFFFF));
          t[$urandom_range(0, 3)] = 0;
        end
      endcase
      send(t[0], t[1], t[2], t[3], 0, '{0, 0, 0, 0, STAT_OK});
    end
  endtask

  row_t directed[19] = '{
    '{0, 0, 0, 0, 1, '{0, 0, 0, 0, STAT_ZERO}},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1, '{0, 0, 0, 0, STAT_ZERO}},
    '{0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, '{0, 0, 0, 0, STAT_ZERO}},
    '{1, 0, 1, 1, 1, '{0, 0, 0, 0, STAT_ZERO}},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, '{0, 0, 0, 0, STAT_OK}},
    '{1, 1, 1, 1, 1, '{0, 0, 0, 0, STAT_OK}},
    '{583000, 583000, 583000, 583000, 1, '{0, 0, 0, 0, STAT_OK}},
    '{1, 24'hFFFFFF, 1, 24'hFFFFFF, 0, '{0, 0, 0, 0, STAT_OK}},
    '{24'hFFFFFF, 1, 24'hFFFFFF, 1, 0, '{0, 0, 0, 0, STAT_OK}},
    '{1, 2, 24'hFFFFFF, 1, 0, '{0, 0, 0, 0, STAT_OK}},
    '{580000, 586000, 583000, 583000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{586000, 580000, 583000, 583000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{583000, 583000, 580000, 586000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{583000, 583000, 586000, 580000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{580000, 586000, 586000, 580000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{586000, 580000, 586000, 580000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{582990, 583000, 570000, 597000, 0, '{0, 0, 0, 0, STAT_OK}},
    '{100, 24'hFFFFFF, 583000, 583001, 0, '{0, 0, 0, 0, STAT_OK}},
    '{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 0, '{0, 0, 0, 0, STAT_OK}}
  };

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i])
      send(directed[i].xp, directed[i].xn, directed[i].yp, directed[i].yn,
           directed[i].known, directed[i].w);
    random_items(100);
    settle();
    write_path(REG_X_PATH, 20'd1000000);
    write_path(REG_Y_PATH, 20'd1000000);
    random_items(90);
    settle();
    write_path(REG_X_PATH, 20'd1000);
    write_path(REG_Y_PATH, 20'hFFFFF);
    random_items(90);
    settle();
    write_path(REG_X_PATH, 20'd0);
    write_path(REG_Y_PATH, 20'd1000);
    random_items(70);
    settle();
    write_path(REG_X_PATH, PATH_W'($urandom_range(1000, 1000000)));
    write_path(REG_Y_PATH, PATH_W'($urandom_range(1000, 1000000)));
    random_items(130);
    settle();
    $display("Sent %0d wind measurements over five path settings, checked %0d results.",
             items_sent, results_seen);
    $display("Settings included zero, minimum, maximum and full-width path lengths.");
    if (errors == 0 && pending_winds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
